>>> hdl/sorted_open_list_queue_defines.svh
// Assertion macros for the sorted open list queue.
// Included by the top level; depends on nothing else.
`ifndef SORTED_OPEN_LIST_QUEUE_DEFINES_SVH
`define SORTED_OPEN_LIST_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SOQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SOQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/soq_pkg.sv
// Shared sizes, payload types, cell control codes and controller states
// for the sorted open list queue. No dependencies.
`default_nettype none

package soq_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int COORD_BITS  = 10;
   localparam int COST_BITS   = 16;
   localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [COST_BITS-1:0]  cost_type;
   typedef logic [CNT_BITS-1:0]   cnt_type;

   typedef enum logic [1:0] {
      OP_PUSH     = 2'd0,
      OP_POP      = 2'd1,
      OP_CONTAINS = 2'd2,
      OP_UPDATE   = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type opcode;
      coord_type  x;
      coord_type  y;
      cost_type   dist_req;
      cost_type   priority_req;
      coord_type  parent_x;
      coord_type  parent_y;
   } req_type;

   typedef struct packed {
      coord_type out_x;
      coord_type out_y;
      cost_type  out_dist;
      cost_type  out_priority;
      coord_type out_parent_x;
      coord_type out_parent_y;
      logic      entry_valid;
      logic      found;
      logic      error;
      cnt_type   count;
   } rsp_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      cost_type  start_dist;
      cost_type  prio;
      coord_type par_x;
      coord_type par_y;
   } entry_type;

   // An entry as it sits in a cell; moved marks an entry hit by a contains or an update.
   typedef struct packed {
      entry_type entry;
      logic      moved;
   } slot_type;

   typedef enum logic [2:0] {
      CELL_HOLD   = 3'd0,
      CELL_PUSH   = 3'd1,
      CELL_POP    = 3'd2,
      CELL_MARK   = 3'd3,
      CELL_UPDATE = 3'd4,
      CELL_SORT   = 3'd5
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      entry_type   item;
      logic        phase;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_REDUCE = 2'd1,
      ST_SORT   = 2'd2,
      ST_FINISH = 2'd3
   } state_type;

endpackage

`default_nettype wire

>>> hdl/soq_req_if.sv
// Request channel of the sorted open list queue: valid, ready and payload.
// Depends on soq_pkg for the payload type.
`default_nettype none

interface soq_req_if;
   import soq_pkg::*;

   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> hdl/soq_rsp_if.sv
// Response channel of the sorted open list queue: valid, ready and payload.
// Depends on soq_pkg for the payload type.
`default_nettype none

interface soq_rsp_if;
   import soq_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> hdl/soq_cell.sv
// One cell of the sorted chain: holds a single entry and trades it with its
// neighbors on push, pop and the odd-even exchange passes. Uses soq_pkg.
`default_nettype none

module soq_cell import soq_pkg::*; (
   input  wire logic         clock,
   input  wire cell_ctl_type ctl,
   input  wire logic         occupied,
   input  wire logic         occupied_right,
   input  wire logic         pair_low,
   input  wire slot_type     left_slot,
   input  wire slot_type     right_slot,
   input  wire logic         left_ins,
   input  wire logic         left_swap,
   output      slot_type     slot,
   output      logic         ins,
   output      logic         swap_right
);

   slot_type slot_ff;
   slot_type slot_in;
   logic     hit;

   assign slot = slot_ff;

   // Everything from the first entry of greater priority onward moves right.
   assign ins = !occupied || (slot_ff.entry.prio > ctl.item.prio);

   assign hit = occupied && (slot_ff.entry.x == ctl.item.x) &&
                (slot_ff.entry.y == ctl.item.y);

   // Moved entries sort behind unmoved entries of equal priority.
   assign swap_right = occupied_right &&
                       ((slot_ff.entry.prio > right_slot.entry.prio) ||
                        ((slot_ff.entry.prio == right_slot.entry.prio) &&
                         slot_ff.moved && !right_slot.moved));

   always_comb begin
      slot_in = slot_ff;
      unique case (ctl.op)
         CELL_HOLD: begin
            slot_in = slot_ff;
         end
         CELL_PUSH: begin
            if (ins) begin
               slot_in.entry = left_ins ? left_slot.entry : ctl.item;
               slot_in.moved = 1'b0;
            end
         end
         CELL_POP: begin
            slot_in = right_slot;
         end
         CELL_MARK: begin
            slot_in.moved = hit;
         end
         CELL_UPDATE: begin
            slot_in.moved = hit;
            if (hit) begin
               slot_in.entry.prio  = ctl.item.prio;
               slot_in.entry.par_x = ctl.item.par_x;
               slot_in.entry.par_y = ctl.item.par_y;
            end
         end
         CELL_SORT: begin
            if (pair_low && swap_right) begin
               slot_in = right_slot;
            end else if (!pair_low && left_swap) begin
               slot_in = left_slot;
            end
         end
         default: begin
            slot_in = slot_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule

`default_nettype wire

>>> hdl/sorted_open_list_queue.sv
// Top level of the sorted open list queue: controller, fill count, the
// chain of soq_cell instances and the response register. Uses soq_pkg.
//
//   channel   direction   handshake         payload
//   req_bus   in          valid / ready     req_type
//   rsp_bus   out         valid / ready     rsp_type
//
// Push and pop pass from idle to the finish state; contains and update also
// pass through the reduce state. When an update matches an entry and at least
// two entries are held, the cells then run N odd-even exchange passes over the
// chain for N held entries to move the updated entries into place before the
// finish state.
// Reset clears the fill count, the controller and the response valid; cell
// contents are never cleared, only entries below the fill count are read.
// A new request is taken as soon as the controller is idle, even while the
// last response still waits; a finished result waits until the response
// register is free.
`default_nettype none

module sorted_open_list_queue import soq_pkg::*; (
   input wire logic  clock,
   input wire logic  reset,
   soq_req_if.sink   req_bus,
   soq_rsp_if.source rsp_bus
);

`include "sorted_open_list_queue_defines.svh"

   state_type    state_ff, state_in;
   cnt_type      count_ff, count_in;
   cnt_type      phase_ff, phase_in;
   opcode_type   op_ff, op_in;
   logic         err_ff, err_in;
   logic         found_ff, found_in;
   entry_type    pop_entry_ff, pop_entry_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_ff, rsp_in;
   cell_ctl_type ctl;

   logic         req_acc;
   logic         full;
   logic         empty;
   logic         found_any;
   entry_type    req_item;
   entry_type    shown;
   logic         shown_valid;

   slot_type                 slot_w [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]   ins_w;
   logic [QUEUE_DEPTH-1:0]   swap_w;
   logic [QUEUE_DEPTH-1:0]   occ_w;
   logic [QUEUE_DEPTH-1:0]   moved_w;

   assign req_bus.ready   = (state_ff == ST_IDLE);
   assign req_acc         = req_bus.valid && req_bus.ready;
   assign full            = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign empty           = (count_ff == '0);
   assign found_any       = |moved_w;
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_ff;

   assign req_item.x          = req_bus.payload.x;
   assign req_item.y          = req_bus.payload.y;
   assign req_item.start_dist = req_bus.payload.dist_req;
   assign req_item.prio       = req_bus.payload.priority_req;
   assign req_item.par_x      = req_bus.payload.parent_x;
   assign req_item.par_y      = req_bus.payload.parent_y;

   genvar i;
   generate
      for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
         localparam logic PARITY = 1'(i % 2);
         slot_type left_slot;
         slot_type right_slot;
         logic     left_ins;
         logic     left_swap;
         logic     occ_right;

         assign occ_w[i]   = (count_ff > CNT_BITS'(i));
         assign moved_w[i] = slot_w[i].moved && occ_w[i];

         if (i == 0) begin : g_first
            assign left_slot = '0;
            assign left_ins  = 1'b0;
            assign left_swap = 1'b0;
         end else begin : g_inner
            assign left_slot = slot_w[i-1];
            assign left_ins  = ins_w[i-1];
            assign left_swap = swap_w[i-1];
         end

         if (i == QUEUE_DEPTH - 1) begin : g_last
            assign right_slot = '0;
            assign occ_right  = 1'b0;
         end else begin : g_body
            assign right_slot = slot_w[i+1];
            assign occ_right  = occ_w[i+1];
         end

         soq_cell u_cell (
            .clock          (clock),
            .ctl            (ctl),
            .occupied       (occ_w[i]),
            .occupied_right (occ_right),
            .pair_low       (ctl.phase == PARITY),
            .left_slot      (left_slot),
            .right_slot     (right_slot),
            .left_ins       (left_ins),
            .left_swap      (left_swap),
            .slot           (slot_w[i]),
            .ins            (ins_w[i]),
            .swap_right     (swap_w[i])
         );
      end
   endgenerate

   // Entry shown in the response: the popped one for pop, else the head.
   always_comb begin
      if (op_ff == OP_POP) begin
         shown       = pop_entry_ff;
         shown_valid = !err_ff;
      end else begin
         shown       = slot_w[0].entry;
         shown_valid = !empty;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      phase_in     = phase_ff;
      op_in        = op_ff;
      err_in       = err_ff;
      found_in     = found_ff;
      pop_entry_in = pop_entry_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_in       = rsp_ff;
      ctl.op       = CELL_HOLD;
      ctl.item     = req_item;
      ctl.phase    = phase_ff[0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               op_in        = req_bus.payload.opcode;
               err_in       = 1'b0;
               found_in     = 1'b0;
               pop_entry_in = slot_w[0].entry;
               state_in     = ST_FINISH;
               unique case (req_bus.payload.opcode)
                  OP_PUSH: begin
                     if (full) begin
                        err_in = 1'b1;
                     end else begin
                        ctl.op   = CELL_PUSH;
                        count_in = count_ff + CNT_BITS'(1);
                     end
                  end
                  OP_POP: begin
                     if (empty) begin
                        err_in = 1'b1;
                     end else begin
                        ctl.op   = CELL_POP;
                        count_in = count_ff - CNT_BITS'(1);
                     end
                  end
                  OP_CONTAINS: begin
                     ctl.op   = CELL_MARK;
                     state_in = ST_REDUCE;
                  end
                  OP_UPDATE: begin
                     ctl.op   = CELL_UPDATE;
                     state_in = ST_REDUCE;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_REDUCE: begin
            found_in = found_any;
            phase_in = '0;
            if ((op_ff == OP_UPDATE) && found_any && (count_ff > CNT_BITS'(1))) begin
               state_in = ST_SORT;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SORT: begin
            ctl.op   = CELL_SORT;
            phase_in = phase_ff + CNT_BITS'(1);
            if (phase_ff == count_ff - CNT_BITS'(1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in        = 1'b1;
               rsp_in              = '0;
               rsp_in.entry_valid  = shown_valid;
               rsp_in.found        = found_ff;
               rsp_in.error        = err_ff;
               rsp_in.count        = count_ff;
               if (shown_valid) begin
                  rsp_in.out_x        = shown.x;
                  rsp_in.out_y        = shown.y;
                  rsp_in.out_dist     = shown.start_dist;
                  rsp_in.out_priority = shown.prio;
                  rsp_in.out_parent_x = shown.par_x;
                  rsp_in.out_parent_y = shown.par_y;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff     <= phase_in;
      op_ff        <= op_in;
      err_ff       <= err_in;
      found_ff     <= found_in;
      pop_entry_ff <= pop_entry_in;
      rsp_ff       <= rsp_in;
   end

   `SOQ_ASSERT_NEXT(a_push_grows, clock, reset,
      req_acc && (req_bus.payload.opcode == OP_PUSH) && !full,
      count_ff == $past(count_ff) + CNT_BITS'(1), "push did not add an entry")
   `SOQ_ASSERT_NEXT(a_pop_shrinks, clock, reset,
      req_acc && (req_bus.payload.opcode == OP_POP) && !empty,
      count_ff == $past(count_ff) - CNT_BITS'(1), "pop did not remove an entry")
   `SOQ_ASSERT_NOW(a_sort_needs_pairs, clock, reset,
      state_ff == ST_SORT, count_ff > CNT_BITS'(1), "exchange pass with fewer than two entries")

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// Testbench for sorted_open_list_queue: random and directed push, pop, contains
// and update requests, checked against an in-bench sorted list model.
// Depends on soq_pkg, soq_req_if, soq_rsp_if and the RTL top level.
module tb import soq_pkg::*;;

   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_CYCLES = 300;
   localparam int END_CYCLES  = 100;
   localparam int POOL_SIZE   = 12;

   logic clock;
   logic reset;

   soq_req_if req_bus ();
   soq_rsp_if rsp_bus ();

   sorted_open_list_queue dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Model of the open list: entries sorted by priority, head first.
   entry_type open_list[$];

   req_type request_backlog[$];
   rsp_type awaited_results[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_tickets = 0;
   int holds_started = 0;
   int hold_left = 0;
   int failures = 0;
   int stall_cycles = 0;

   // Request planning state.
   int planned_count = 0;
   int planned_items = 0;
   logic [2*COORD_BITS-1:0] coord_pool[$];

   always #2 clock = ~clock;

   function automatic rsp_type describe_entry(input logic have, input entry_type e,
                                              input logic hit, input logic err);
      rsp_type o;
      o = '0;
      if (have) begin
         o.out_x        = e.x;
         o.out_y        = e.y;
         o.out_dist     = e.start_dist;
         o.out_priority = e.prio;
         o.out_parent_x = e.par_x;
         o.out_parent_y = e.par_y;
      end
      o.entry_valid = have;
      o.found       = hit;
      o.error       = err;
      o.count       = cnt_type'(open_list.size());
      return o;
   endfunction

   // An entry goes behind every entry whose priority is not greater.
   task automatic insert_by_priority(input entry_type e);
      int idx;
      idx = 0;
      while (idx < open_list.size() && open_list[idx].prio <= e.prio)
         idx++;
      open_list.insert(idx, e);
   endtask

   task automatic predict_queue_result(input req_type r, output rsp_type o);
      entry_type e;
      entry_type kept[$];
      entry_type moved[$];
      logic hit;
      logic err;
      logic popped;
      hit = 1'b0;
      err = 1'b0;
      popped = 1'b0;
      e.x          = r.x;
      e.y          = r.y;
      e.start_dist = r.dist_req;
      e.prio       = r.priority_req;
      e.par_x      = r.parent_x;
      e.par_y      = r.parent_y;
      case (r.opcode)
         OP_PUSH: begin
            if (open_list.size() >= QUEUE_DEPTH)
               err = 1'b1;
            else
               insert_by_priority(e);
         end
         OP_POP: begin
            if (open_list.size() == 0) begin
               err = 1'b1;
            end else begin
               e = open_list.pop_front();
               popped = 1'b1;
            end
         end
         OP_CONTAINS: begin
            foreach (open_list[i])
               if (open_list[i].x == r.x && open_list[i].y == r.y)
                  hit = 1'b1;
         end
         default: begin
            // Matching entries leave the list and go back in, in their old order.
            foreach (open_list[i]) begin
               if (open_list[i].x == r.x && open_list[i].y == r.y) begin
                  e = open_list[i];
                  e.prio  = r.priority_req;
                  e.par_x = r.parent_x;
                  e.par_y = r.parent_y;
                  moved.push_back(e);
               end else begin
                  kept.push_back(open_list[i]);
               end
            end
            open_list = kept;
            hit = (moved.size() != 0);
            foreach (moved[i])
               insert_by_priority(moved[i]);
         end
      endcase
      if (r.opcode == OP_POP)
         o = describe_entry(popped, e, 1'b0, err);
      else if (open_list.size() != 0)
         o = describe_entry(1'b1, open_list[0], hit, err);
      else
         o = describe_entry(1'b0, e, hit, err);
   endtask

   // Request driver.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_queue_result(req_bus.payload, want);
            awaited_results.push_back(want);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_bus.valid   <= 1'b1;
               req_bus.payload <= request_backlog.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Response receiver: random stalls, plus long hold-offs on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (holds_started != hold_tickets) begin
         holds_started++;
         hold_left = HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic report_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
      if (exp_v != act_v) begin
         $error("tb: %s expected 0x%0h got 0x%0h", name, exp_v, act_v);
         failures++;
      end
   endtask

   // Response monitor.
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = rsp_bus.payload;
         if (awaited_results.size() == 0) begin
            $error("tb: response with no request outstanding");
            failures++;
         end else begin
            want = awaited_results.pop_front();
            report_field("out_x", want.out_x, got.out_x);
            report_field("out_y", want.out_y, got.out_y);
            report_field("out_dist", want.out_dist, got.out_dist);
            report_field("out_priority", want.out_priority, got.out_priority);
            report_field("out_parent_x", want.out_parent_x, got.out_parent_x);
            report_field("out_parent_y", want.out_parent_y, got.out_parent_y);
            report_field("entry_valid", want.entry_valid, got.entry_valid);
            report_field("found", want.found, got.found);
            report_field("error", want.error, got.error);
            report_field("count", want.count, got.count);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin : watchdog
      wait (stall_cycles >= STALL_LIMIT);
      $display("tb: FAIL");
      $finish;
   end

   task automatic plan_request(input opcode_type op, input coord_type x, input coord_type y,
                               input cost_type d, input cost_type p,
                               input coord_type px, input coord_type py);
      req_type r;
      r.opcode       = op;
      r.x            = x;
      r.y            = y;
      r.dist_req     = d;
      r.priority_req = p;
      r.parent_x     = px;
      r.parent_y     = py;
      request_backlog.push_back(r);
      planned_items++;
      if (op == OP_PUSH) begin
         if (planned_count < QUEUE_DEPTH)
            planned_count++;
         if (coord_pool.size() < POOL_SIZE)
            coord_pool.push_back({x, y});
         else
            coord_pool[$urandom_range(POOL_SIZE - 1)] = {x, y};
      end else if (op == OP_POP && planned_count > 0) begin
         planned_count--;
      end
   endtask

   // Coordinates are often reused so that contains and update hit, and so
   // that several entries share one coordinate.
   task automatic plan_random(input opcode_type op);
      logic [2*COORD_BITS-1:0] xy;
      cost_type p;
      xy = {coord_type'($urandom), coord_type'($urandom)};
      if (coord_pool.size() != 0 && $urandom_range(9) < (op == OP_PUSH ? 4 : 7))
         xy = coord_pool[$urandom_range(coord_pool.size() - 1)];
      case ($urandom_range(3))
         0, 1: p = cost_type'($urandom_range(15));
         2: p = cost_type'($urandom);
         default: p = $urandom_range(1) ? '1 : '0;
      endcase
      plan_request(op, xy[2*COORD_BITS-1:COORD_BITS], xy[COORD_BITS-1:0],
                   cost_type'($urandom), p, coord_type'($urandom), coord_type'($urandom));
   endtask

   function automatic opcode_type pick_op(input int push_w, input int pop_w,
                                          input int contains_w);
      int roll;
      roll = $urandom_range(99);
      if (roll < push_w)
         return OP_PUSH;
      if (roll < push_w + pop_w)
         return OP_POP;
      if (roll < push_w + pop_w + contains_w)
         return OP_CONTAINS;
      return OP_UPDATE;
   endfunction

   task automatic wait_until_idle();
      while (request_backlog.size() != 0 || req_bus.valid || awaited_results.size() != 0)
         @(posedge clock);
   endtask

   // Cycles through filling past full, draining past empty and mixed traffic.
   task automatic run_bursts(input int quota);
      int target;
      int burst;
      target = planned_items + quota;
      burst = 0;
      while (planned_items < target) begin
         case (burst % 3)
            0: begin
               while (planned_count < QUEUE_DEPTH)
                  plan_random(pick_op(85, 0, 8));
               repeat (1 + $urandom_range(3))
                  plan_random(OP_PUSH);
            end
            1: begin
               while (planned_count > 0)
                  plan_random(pick_op(0, 85, 8));
               repeat (1 + $urandom_range(2))
                  plan_random(OP_POP);
            end
            default: begin
               repeat (30 + $urandom_range(20))
                  plan_random(pick_op(35, 30, 15));
            end
         endcase
         burst++;
         if ($urandom_range(2) == 0)
            wait_until_idle();
      end
      wait_until_idle();
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      rsp_bus.ready   = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 21;
      recv_idle_pct = 86;

      // Empty queue cases first, then extremes, ties and updates.
      plan_request(OP_POP, 0, 0, 0, 0, 0, 0);
      plan_request(OP_CONTAINS, 0, 0, 0, 0, 0, 0);
      plan_request(OP_UPDATE, 0, 0, 0, 16'h0005, 1, 1);
      plan_request(OP_PUSH, 0, 0, 0, 0, 0, 0);
      plan_request(OP_PUSH, '1, '1, '1, '1, '1, '1);
      plan_request(OP_PUSH, 5, 7, 16'h0123, 16'h0010, 1, 2);
      plan_request(OP_PUSH, 9, 9, 16'h0456, 16'h0010, 2, 2);
      plan_request(OP_PUSH, 5, 7, 16'h0789, 16'h0010, 3, 3);
      plan_request(OP_CONTAINS, 5, 7, 0, 0, 0, 0);
      plan_request(OP_CONTAINS, 100, 200, 0, 0, 0, 0);
      plan_request(OP_UPDATE, 5, 7, 0, 16'h0008, 4, 4);
      plan_request(OP_UPDATE, 77, 77, 0, 16'h0001, 6, 6);
      plan_request(OP_UPDATE, 0, 0, 0, '1, 10'h2AA, 10'h155);
      plan_request(OP_UPDATE, 9, 9, 0, 0, 10'h155, 10'h2AA);
      repeat (6)
         plan_request(OP_POP, 0, 0, 0, 0, 0, 0);
      wait_until_idle();

      run_bursts(260);

      send_idle_pct = 86;
      recv_idle_pct = 21;
      run_bursts(260);

      // No idling; the receiver holds off early so the block backs up.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_tickets++;
      run_bursts(260);

      repeat (END_CYCLES) @(posedge clock);
      if (failures == 0 && awaited_results.size() == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
